### design/sphere_lattice_point_enumerator_assert.svh
// Assertion macros shared by the enumerator RTL.
`ifndef SPHERE_LATTICE_POINT_ENUMERATOR_ASSERT_SVH
`define SPHERE_LATTICE_POINT_ENUMERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SLPE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define SLPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SLPE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define SLPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/slpe_pkg.sv
package slpe_pkg;

    localparam int MAX_RADIUS = 255;
    localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
    // Offsets run from -r to r + 1, so two bits beyond the radius.
    localparam int OFF_W      = RAD_W + 2;
    localparam int SQ_W       = 2 * RAD_W;
    localparam int ACC_W      = SQ_W + 2;
    localparam int RIN_W      = 8;
    localparam int CIN_W      = 31;
    localparam int COUT_W     = 32;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    typedef logic signed [CIN_W-1:0]  t_coord_in;
    typedef logic signed [COUT_W-1:0] t_coord_out;
    typedef logic        [RIN_W-1:0]  t_radius_in;

endpackage

### design/slpe_if.sv
interface slpe_in_if;
    import slpe_pkg::*;

    logic       valid;
    logic       ready;
    logic       mode;
    t_coord_in  center_x;
    t_coord_in  center_y;
    t_coord_in  center_z;
    t_radius_in radius;

    modport source (output valid, mode, center_x, center_y, center_z, radius, input ready);
    modport sink   (input valid, mode, center_x, center_y, center_z, radius, output ready);
endinterface

interface slpe_out_if;
    import slpe_pkg::*;

    logic       valid;
    logic       ready;
    t_coord_out point_x;
    t_coord_out point_y;
    t_coord_out point_z;
    logic       last;

    modport source (output valid, point_x, point_y, point_z, last, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last, output ready);
endinterface

### design/sphere_lattice_point_enumerator.sv
// Walks every lattice point inside a sphere, x ascending, then y, then z. A start item
// (mode 0) loads centre and radius and returns nothing; each advance item (mode 1) made
// while a sphere is active returns the next point, and the final point carries last. The
// input is ready only while the block is idle. Within a column an advance's point is
// offered in the cycle after the item is taken. Moving to a new column means testing
// columns and stepping to new x planes in turn (empty columns are stepped past one per
// cycle, with squares kept incrementally), then taking the bit-pair integer square root
// of the column's remainder. A start item keeps the input busy until its first column is
// found and its root taken; an advance that ends a column offers its point only after
// the next column is found and its root taken, or after the scan passes x = r.
`include "sphere_lattice_point_enumerator_assert.svh"

module sphere_lattice_point_enumerator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slpe_in_if.sink    i_in_ch,
    slpe_out_if.source o_out_ch
);
    import slpe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETTLE,
        S_SQRT,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic                    r_active;
    logic                    r_emit;
    logic                    r_last;
    t_coord_in               r_org_x;
    t_coord_in               r_org_y;
    t_coord_in               r_org_z;
    logic        [RAD_W-1:0] r_radius;
    logic        [SQ_W-1:0]  r_r2;
    logic signed [OFF_W-1:0] r_off_x;
    logic signed [OFF_W-1:0] r_off_y;
    logic signed [OFF_W-1:0] r_off_z;
    logic        [RAD_W-1:0] r_hs;
    logic signed [ACC_W-1:0] r_rx;
    logic signed [ACC_W-1:0] r_y2;
    logic        [SQ_W-1:0]  r_val;
    logic        [SQ_W-1:0]  r_root;
    logic        [SQ_W-1:0]  r_bit;
    t_coord_out              r_px;
    t_coord_out              r_py;
    t_coord_out              r_pz;

    logic        [RAD_W-1:0] w_rad_sat;
    logic        [SQ_W-1:0]  w_r2_in;
    logic signed [OFF_W-1:0] w_r_ext;
    logic signed [OFF_W-1:0] w_hs_ext;
    logic signed [ACC_W-1:0] w_rem;
    logic signed [ACC_W-1:0] w_dx;
    logic signed [ACC_W-1:0] w_dy;
    logic                    w_x_past;
    logic                    w_y_past;
    logic        [SQ_W-1:0]  w_try;
    logic                    w_fits;
    logic        [SQ_W-1:0]  n_root;
    logic        [SQ_W-1:0]  n_val;
    logic                    w_accept;

    always_comb begin
        if (32'(i_in_ch.radius) > 32'(MAX_RADIUS)) begin
            w_rad_sat = RAD_W'(MAX_RADIUS);
        end else begin
            w_rad_sat = RAD_W'(i_in_ch.radius);
        end
        w_r2_in  = SQ_W'(w_rad_sat) * SQ_W'(w_rad_sat);
        w_r_ext  = signed'({2'b00, r_radius});
        w_hs_ext = signed'({2'b00, r_hs});
        w_rem    = r_rx - r_y2;
        // (x + 1)^2 - x^2 = 2x + 1, likewise for y.
        w_dx     = (ACC_W'(r_off_x) <<< 1) + ACC_W'(1);
        w_dy     = (ACC_W'(r_off_y) <<< 1) + ACC_W'(1);
        w_x_past = r_off_x > w_r_ext;
        w_y_past = r_off_y > w_r_ext;
        w_try    = r_root + r_bit;
        w_fits   = r_val >= w_try;
        if (w_fits) begin
            n_val  = r_val - w_try;
            n_root = (r_root >> 1) + r_bit;
        end else begin
            n_val  = r_val;
            n_root = r_root >> 1;
        end
    end

    assign w_accept         = i_in_ch.valid && i_in_ch.ready;
    assign i_in_ch.ready    = (r_state == S_IDLE);
    assign o_out_ch.valid   = (r_state == S_OUT);
    assign o_out_ch.point_x = r_px;
    assign o_out_ch.point_y = r_py;
    assign o_out_ch.point_z = r_pz;
    assign o_out_ch.last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_emit   <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in_ch.mode == MODE_START) begin
                            r_org_x  <= i_in_ch.center_x;
                            r_org_y  <= i_in_ch.center_y;
                            r_org_z  <= i_in_ch.center_z;
                            r_radius <= w_rad_sat;
                            r_r2     <= w_r2_in;
                            r_y2     <= signed'(ACC_W'(w_r2_in));
                            r_rx     <= '0;
                            r_off_x  <= -signed'({2'b00, w_rad_sat});
                            r_off_y  <= -signed'({2'b00, w_rad_sat});
                            r_emit   <= 1'b0;
                            r_state  <= S_SETTLE;
                        end else if (r_active) begin
                            r_px <= COUT_W'(r_org_x) + COUT_W'(r_off_x);
                            r_py <= COUT_W'(r_org_y) + COUT_W'(r_off_y);
                            r_pz <= COUT_W'(r_org_z) + COUT_W'(r_off_z);
                            if (r_off_z < w_hs_ext) begin
                                r_off_z <= r_off_z + OFF_W'(1);
                                r_last  <= 1'b0;
                                r_state <= S_OUT;
                            end else begin
                                r_off_y <= r_off_y + OFF_W'(1);
                                r_y2    <= r_y2 + w_dy;
                                r_emit  <= 1'b1;
                                r_state <= S_SETTLE;
                            end
                        end
                    end
                end
                S_SETTLE: begin
                    if (w_x_past) begin
                        r_active <= 1'b0;
                        r_last   <= 1'b1;
                        r_state  <= r_emit ? S_OUT : S_IDLE;
                    end else if (w_y_past) begin
                        r_off_x <= r_off_x + OFF_W'(1);
                        r_rx    <= r_rx - w_dx;
                        r_off_y <= -w_r_ext;
                        r_y2    <= signed'(ACC_W'(r_r2));
                    end else if (!w_rem[ACC_W-1]) begin
                        r_val   <= w_rem[SQ_W-1:0];
                        r_root  <= '0;
                        r_bit   <= SQ_W'(1) << (SQ_W - 2);
                        r_state <= S_SQRT;
                    end else begin
                        r_off_y <= r_off_y + OFF_W'(1);
                        r_y2    <= r_y2 + w_dy;
                    end
                end
                S_SQRT: begin
                    r_val  <= n_val;
                    r_root <= n_root;
                    r_bit  <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_hs     <= n_root[RAD_W-1:0];
                        r_off_z  <= -signed'({2'b00, n_root[RAD_W-1:0]});
                        r_active <= 1'b1;
                        r_last   <= 1'b0;
                        r_state  <= r_emit ? S_OUT : S_IDLE;
                    end
                end
                S_OUT: begin
                    if (o_out_ch.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SLPE_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_out_ch.valid, !i_in_ch.ready,
                      "input taken while a point is pending")
    `SLPE_ASSERT_IMPL(a_root_bit, i_clk, i_rst_n, r_state == S_SQRT, $onehot(r_bit),
                      "square-root bit not one-hot")
    `SLPE_ASSERT_IMPL(a_last_idle, i_clk, i_rst_n, o_out_ch.valid && o_out_ch.last,
                      !r_active, "last point offered while sphere still active")
    `SLPE_ASSERT_NEXT(a_start_scan, i_clk, i_rst_n, w_accept && i_in_ch.mode == MODE_START,
                      r_state == S_SETTLE, "start item did not begin the column scan")

endmodule

### sim/sphere_lattice_point_enumerator_test.sv
`timescale 1ns / 1ps

module sphere_lattice_point_enumerator_test;
    import slpe_pkg::*;

    localparam int CMAX        = 1073741823;
    localparam int CMIN        = -1073741824;
    localparam int ITEM_COUNT  = 1200;
    localparam int DRAIN_WAIT  = 600;
    localparam int LONG_HOLD   = 400;

    typedef enum logic [1:0] {ROW_NONE, ROW_TYPED, ROW_PRED} t_row_kind;

    typedef struct packed {
        logic       mode;
        t_coord_in  cx;
        t_coord_in  cy;
        t_coord_in  cz;
        t_radius_in r;
    } t_in_item;

    typedef struct packed {
        t_coord_out px;
        t_coord_out py;
        t_coord_out pz;
        logic       last;
    } t_point;

    typedef struct packed {
        t_row_kind kind;
        t_in_item  stim;
        t_point    pt;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    slpe_in_if  in_ch ();
    slpe_out_if out_ch ();

    sphere_lattice_point_enumerator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    // Walker state of the sphere being enumerated.
    int org_x, org_y, org_z;
    int rad;
    int off_x, off_y, off_z;
    int span;
    bit walking;

    t_point   pending_points[$];
    t_dir_row directed_rows[$];

    int  mismatches;
    int  items_sent;
    int  starts_sent;
    int  points_checked;
    int  spheres_done;
    int  max_radius_seen;
    int  burst_left;
    bit  no_gaps;
    bit  long_hold_done;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    // Finds the first column from the current offset onward whose remainder is
    // non-negative, and loads its half-span; false once x has passed the radius.
    function automatic bit seek_column();
        int rem;
        while (off_x <= rad) begin
            if (off_y > rad) begin
                off_x++;
                off_y = -rad;
            end else begin
                rem = rad * rad - off_x * off_x - off_y * off_y;
                if (rem >= 0) begin
                    span = 0;
                    while ((span + 1) * (span + 1) <= rem) span++;
                    off_z = -span;
                    return 1'b1;
                end
                off_y++;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit step_walker(input t_in_item it, output t_point pt);
        pt = '0;
        if (it.mode == MODE_START) begin
            org_x = it.cx;
            org_y = it.cy;
            org_z = it.cz;
            rad   = it.r;
            if (rad > MAX_RADIUS) rad = MAX_RADIUS;
            off_x   = -rad;
            off_y   = -rad;
            walking = seek_column();
            return 1'b0;
        end
        if (!walking) return 1'b0;
        pt.px = t_coord_out'(org_x + off_x);
        pt.py = t_coord_out'(org_y + off_y);
        pt.pz = t_coord_out'(org_z + off_z);
        if (off_z < span) begin
            off_z++;
        end else begin
            off_y++;
            walking = seek_column();
        end
        pt.last = !walking;
        return 1'b1;
    endfunction

    function automatic t_coord_in rand_coord();
        case ($urandom_range(0, 7))
            0:       return t_coord_in'(CMAX);
            1:       return t_coord_in'(CMIN);
            default: return t_coord_in'($urandom);
        endcase
    endfunction

    function automatic t_in_item make_item(input logic mode, input int r);
        t_in_item it;
        it.mode = mode;
        it.cx   = rand_coord();
        it.cy   = rand_coord();
        it.cz   = rand_coord();
        it.r    = t_radius_in'(r);
        return it;
    endfunction

    function automatic void add_row(input t_row_kind kind, input logic mode,
                                    input int cx, input int cy, input int cz, input int r,
                                    input int px, input int py, input int pz,
                                    input logic last);
        t_dir_row row;
        row.kind    = kind;
        row.stim    = '{mode, t_coord_in'(cx), t_coord_in'(cy), t_coord_in'(cz),
                        t_radius_in'(r)};
        row.pt      = '{t_coord_out'(px), t_coord_out'(py), t_coord_out'(pz), last};
        directed_rows.push_back(row);
    endfunction

    // Drives one item in bursts, waits for it to be taken, then records the
    // point it should produce (or the typed one for typed rows).
    task automatic offer(input t_in_item it, input t_row_kind kind, input t_point typed_pt);
        t_point pt;
        bit     has_pt;
        int     gap;
        if (burst_left == 0) begin
            gap = no_gaps ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= it.mode;
        in_ch.center_x <= it.cx;
        in_ch.center_y <= it.cy;
        in_ch.center_z <= it.cz;
        in_ch.radius   <= it.r;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (it.mode == MODE_START) begin
            starts_sent++;
            if (it.r > max_radius_seen) max_radius_seen = it.r;
        end
        has_pt = step_walker(it, pt);
        if (has_pt && pt.last) spheres_done++;
        if (kind == ROW_TYPED) begin
            pending_points.push_back(typed_pt);
        end else if (kind == ROW_PRED && has_pt) begin
            pending_points.push_back(pt);
        end
    endtask

    // Receiver: switches at random among always ready, random ready and mostly stalled, and once
    // holds off for a long stretch so that the block backs up.
    initial begin
        int pat_kind;
        int pat_left;
        pat_left = 0;
        pat_kind = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!long_hold_done && points_checked >= 150) begin
                long_hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            if (pat_left == 0) begin
                pat_kind = $urandom_range(0, 2);
                pat_left = $urandom_range(10, 60);
            end
            pat_left--;
            case (pat_kind)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_point exp_pt;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: expected no point, got (%0d, %0d, %0d) last %0b", $realtime,
                         out_ch.point_x, out_ch.point_y, out_ch.point_z, out_ch.last);
                mismatches++;
            end else begin
                exp_pt = pending_points.pop_front();
                points_checked++;
                if (out_ch.point_x !== exp_pt.px) begin
                    $display("%0t: point_x expected %0d, got %0d", $realtime,
                             exp_pt.px, out_ch.point_x);
                    mismatches++;
                end
                if (out_ch.point_y !== exp_pt.py) begin
                    $display("%0t: point_y expected %0d, got %0d", $realtime,
                             exp_pt.py, out_ch.point_y);
                    mismatches++;
                end
                if (out_ch.point_z !== exp_pt.pz) begin
                    $display("%0t: point_z expected %0d, got %0d", $realtime,
                             exp_pt.pz, out_ch.point_z);
                    mismatches++;
                end
                if (out_ch.last !== exp_pt.last) begin
                    $display("%0t: last expected %0b, got %0b", $realtime,
                             exp_pt.last, out_ch.last);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("%0t: timed out with %0d points outstanding", $realtime,
                 pending_points.size());
        $display("sphere_lattice_point_enumerator_test failed");
        $finish;
    end

    initial begin
        t_in_item it;
        int       sel;
        int       r;
        int       walk_limit;
        int       n;
        mismatches      = 0;
        items_sent      = 0;
        starts_sent     = 0;
        points_checked  = 0;
        spheres_done    = 0;
        max_radius_seen = 0;
        burst_left      = 0;
        no_gaps         = 1'b0;
        long_hold_done  = 1'b0;
        org_x = 0; org_y = 0; org_z = 0;
        rad   = 0;
        off_x = 0; off_y = 0; off_z = 0;
        span  = 0;
        walking = 1'b0;

        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_START;
        in_ch.center_x = '0;
        in_ch.center_y = '0;
        in_ch.center_z = '0;
        in_ch.radius   = '0;

        // Advance straight after reset, radius zero at the coordinate extremes,
        // advance after the last point, abandoned spheres and the largest radius.
        add_row(ROW_NONE,  MODE_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_NONE,  MODE_START, CMAX, CMIN, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_TYPED, MODE_ADVANCE, 0, 0, 0, 0, CMAX, CMIN, 0, 1'b1);
        add_row(ROW_NONE,  MODE_ADVANCE, -1, -1, -1, 255, 0, 0, 0, 1'b0);
        add_row(ROW_NONE,  MODE_START, 0, 0, 0, 1, 0, 0, 0, 1'b0);
        add_row(ROW_TYPED, MODE_ADVANCE, 0, 0, 0, 0, -1, 0, 0, 1'b0);
        repeat (5) add_row(ROW_PRED, MODE_ADVANCE, -1, -1, -1, 255, 0, 0, 0, 1'b0);
        add_row(ROW_TYPED, MODE_ADVANCE, 0, 0, 0, 0, 1, 0, 0, 1'b1);
        add_row(ROW_NONE,  MODE_START, CMIN, CMAX, CMIN, 255, 0, 0, 0, 1'b0);
        add_row(ROW_TYPED, MODE_ADVANCE, 0, 0, 0, 0, CMIN - 255, CMAX, CMIN, 1'b0);
        repeat (2) add_row(ROW_PRED, MODE_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_NONE,  MODE_START, CMAX, CMAX, CMAX, 3, 0, 0, 0, 1'b0);
        add_row(ROW_TYPED, MODE_ADVANCE, 0, 0, 0, 0, CMAX - 3, CMAX, CMAX, 1'b0);
        repeat (2) add_row(ROW_PRED, MODE_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        add_row(ROW_NONE,  MODE_START, -1, -1, -1, 128, 0, 0, 0, 1'b0);
        repeat (2) add_row(ROW_PRED, MODE_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 1'b0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer(directed_rows[i].stim, directed_rows[i].kind, directed_rows[i].pt);

        // Mostly whole spheres of small radius, some larger spheres cut short by
        // a new start, and a little noise with random modes.
        while (items_sent < ITEM_COUNT) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            sel     = $urandom_range(0, 99);
            if (sel < 6) begin
                repeat ($urandom_range(1, 4)) begin
                    it = make_item(1'($urandom_range(0, 1)), $urandom_range(0, 255));
                    offer(it, ROW_PRED, '0);
                end
            end else begin
                if (sel < 78)      r = $urandom_range(0, 2);
                else if (sel < 86) r = 3;
                else               r = $urandom_range(4, 255);
                offer(make_item(MODE_START, r), ROW_PRED, '0);
                if (r <= 3 && $urandom_range(0, 9) != 0) walk_limit = 1000;
                else                                     walk_limit = $urandom_range(1, 24);
                n = 0;
                while (walking && n < walk_limit) begin
                    offer(make_item(MODE_ADVANCE, $urandom_range(0, 255)), ROW_PRED, '0);
                    n++;
                end
                if (!walking) begin
                    repeat ($urandom_range(0, 2))
                        offer(make_item(MODE_ADVANCE, $urandom_range(0, 255)),
                              ROW_PRED, '0);
                end
            end
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d items including %0d sphere starts (largest radius %0d).",
                 items_sent, starts_sent, max_radius_seen);
        $display("Checked %0d points; %0d spheres were walked to their final point.",
                 points_checked, spheres_done);
        if (mismatches == 0) begin
            $display("sphere_lattice_point_enumerator_test passed");
        end else begin
            $display("sphere_lattice_point_enumerator_test failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/slpe_pkg.sv
design/slpe_if.sv
design/sphere_lattice_point_enumerator.sv
sim/sphere_lattice_point_enumerator_test.sv
